// File: design/blm_pkg.sv
// Shared types and constants for the battery-low monitor.
`timescale 1ns / 1ps

package blm_pkg;

    localparam int unsigned ALPHA_W = 9;
    localparam int unsigned LEVEL_W = 20;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned ADC_W   = 12;
    localparam int unsigned MODE_W  = 2;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

    localparam logic [MODE_W-1:0] MODE_SAMPLE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACK_SET   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ACK_CLEAR = 2'd2;

    localparam logic [1:0] REG_ALPHA     = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_MIN_INT   = 2'd2;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 9'd26;
    localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 20'd524288;
    localparam logic [TIME_W-1:0]  MIN_INT_RESET   = 32'd60000;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha_q8;
        logic [LEVEL_W-1:0] low_threshold;
        logic [TIME_W-1:0]  min_interval_ms;
    } cfg_t;

endpackage

// File: design/blm_cfg.sv
// APB register block for filter weight, threshold and minimum interval.
`timescale 1ns / 1ps

module blm_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output blm_pkg::cfg_t       cfg
);

    blm_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alpha_q8        <= blm_pkg::ALPHA_RESET;
            cfg_reg.low_threshold   <= blm_pkg::THRESHOLD_RESET;
            cfg_reg.min_interval_ms <= blm_pkg::MIN_INT_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                blm_pkg::REG_ALPHA:     cfg_reg.alpha_q8 <= pwdata[blm_pkg::ALPHA_W-1:0];
                blm_pkg::REG_THRESHOLD: cfg_reg.low_threshold <= pwdata[blm_pkg::LEVEL_W-1:0];
                blm_pkg::REG_MIN_INT:   cfg_reg.min_interval_ms <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            blm_pkg::REG_ALPHA:     prdata = {23'd0, cfg_reg.alpha_q8};
            blm_pkg::REG_THRESHOLD: prdata = {12'd0, cfg_reg.low_threshold};
            blm_pkg::REG_MIN_INT:   prdata = cfg_reg.min_interval_ms;
            default:                prdata = 32'd0;
        endcase
    end

endmodule

// File: design/blm_ema.sv
// Exponential moving average of the converter reading in Q12.8 counts.
`timescale 1ns / 1ps

module blm_ema (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          upd_en,
    input  logic [blm_pkg::ALPHA_W-1:0]   alpha_q8,
    input  logic [blm_pkg::ADC_W-1:0]     adc_sample,
    output logic [blm_pkg::LEVEL_W-1:0]   avg_next,
    output logic [blm_pkg::LEVEL_W-1:0]   avg
);

    logic [blm_pkg::LEVEL_W-1:0] avg_reg;
    logic [blm_pkg::ALPHA_W-1:0] a;
    logic [blm_pkg::ALPHA_W-1:0] a_inv;
    logic [blm_pkg::LEVEL_W-1:0] s;
    logic [29:0]                 mix;

    // saturate weight at one
    assign a     = (alpha_q8 > blm_pkg::ALPHA_ONE) ? blm_pkg::ALPHA_ONE : alpha_q8;
    assign a_inv = blm_pkg::ALPHA_ONE - a;
    assign s     = {adc_sample, 8'd0};

    // round half up before dropping the fraction of the weight
    assign mix = 30'(a) * 30'(s) + 30'(a_inv) * 30'(avg_reg) + 30'd128;
    assign avg_next = mix[blm_pkg::LEVEL_W+7:8];
    assign avg      = avg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_reg <= '0;
        end else if (upd_en) begin
            avg_reg <= avg_next;
        end
    end

endmodule

// File: design/blm_window.sv
// Ring of recent averages and the all-entries-low detector.
`timescale 1ns / 1ps

module blm_window #(
    parameter int unsigned WINDOW_DEPTH = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          upd_en,
    input  logic [blm_pkg::LEVEL_W-1:0]   avg_next,
    input  logic [blm_pkg::LEVEL_W-1:0]   low_threshold,
    output logic                          low_next
);

    localparam int unsigned SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

    logic [blm_pkg::LEVEL_W-1:0] levels_reg [WINDOW_DEPTH];
    logic [SLOT_W-1:0]           slot_reg;
    logic [SLOT_W-1:0]           slot_next;
    logic [WINDOW_DEPTH-1:0]     entry_low;

    assign slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;

    // judge each entry as it will stand after this write
    always_comb begin
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            if (slot_reg == SLOT_W'(i)) begin
                entry_low[i] = (avg_next != '0) && (avg_next < low_threshold);
            end else begin
                entry_low[i] = (levels_reg[i] != '0) && (levels_reg[i] < low_threshold);
            end
        end
    end

    assign low_next = &entry_low;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                levels_reg[i] <= '0;
            end
        end else if (upd_en) begin
            levels_reg[slot_reg] <= avg_next;
            slot_reg             <= slot_next;
        end
    end

endmodule

// File: design/battery_low_monitor_unit.sv
// Top level of the battery-low monitor: word staging, acknowledge latch, result.
//
//  channel | direction | tdata fields (low bit up)                       | tuser
//  s_      | in        | adc_sample[11:0], now_ms[43:12]                 | mode[1:0]
//  m_      | out       | battery_low[0], low_ack[1], filtered_level[21:2] | -
//  apb     | in/out    | alpha_q8 @0x0, low_threshold @0x4, min_interval_ms @0x8
//
// One word per cycle while the output is not stalled; a word is held in the input
// register and its result is then registered into the output register.
// The average, ring, flags and output update together, so the next word sees
// them at once. A stalled output holds the input register; a third word waits.
// Reset is synchronous and active low.
`timescale 1ns / 1ps

module battery_low_monitor_unit #(
    parameter int unsigned WINDOW_DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // adc_sample[11:0], now_ms[43:12], zero pad
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // battery_low[0], low_ack[1], filtered_level[21:2]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    blm_pkg::cfg_t cfg;

    logic                          in_valid_reg;
    logic [blm_pkg::MODE_W-1:0]    in_mode_reg;
    logic [blm_pkg::ADC_W-1:0]     in_adc_reg;
    logic [blm_pkg::TIME_W-1:0]    in_now_reg;
    logic                          out_valid_reg;
    logic                          fire;
    logic                          sample_en;

    logic                          low_flag_reg;
    logic                          low_flag_next;
    logic                          ack_flag_reg;
    logic                          ack_flag_next;
    logic [blm_pkg::TIME_W-1:0]    ack_time_reg;
    logic [blm_pkg::TIME_W-1:0]    ack_time_next;
    logic [blm_pkg::TIME_W-1:0]    interval_reg;
    logic [blm_pkg::TIME_W-1:0]    interval_next;
    logic [blm_pkg::TIME_W-1:0]    elapsed;

    logic [blm_pkg::LEVEL_W-1:0]   avg_next;
    logic [blm_pkg::LEVEL_W-1:0]   avg;
    logic                          low_next;

    assign fire      = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready  = ~in_valid_reg | fire;
    assign sample_en = fire & (in_mode_reg == blm_pkg::MODE_SAMPLE);

    blm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    blm_ema u_ema (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .upd_en     (sample_en),
        .alpha_q8   (cfg.alpha_q8),
        .adc_sample (in_adc_reg),
        .avg_next   (avg_next),
        .avg        (avg)
    );

    blm_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .upd_en        (sample_en),
        .avg_next      (avg_next),
        .low_threshold (cfg.low_threshold),
        .low_next      (low_next)
    );

    assign elapsed = in_now_reg - ack_time_reg;

    always_comb begin
        low_flag_next = low_flag_reg;
        ack_flag_next = ack_flag_reg;
        ack_time_next = ack_time_reg;
        interval_next = interval_reg;
        case (in_mode_reg)
            blm_pkg::MODE_SAMPLE: begin
                low_flag_next = low_next;
                // release on recovery, lapse once the interval has run out
                if (ack_flag_reg && !low_next) begin
                    interval_next = cfg.min_interval_ms;
                end
                ack_flag_next = ack_flag_reg & low_next & (elapsed < interval_reg);
            end
            blm_pkg::MODE_ACK_SET: begin
                ack_flag_next = 1'b1;
                ack_time_next = in_now_reg;
                interval_next = interval_reg[blm_pkg::TIME_W-1] ? '1
                              : {interval_reg[blm_pkg::TIME_W-2:0], 1'b0};
            end
            blm_pkg::MODE_ACK_CLEAR: begin
                ack_flag_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            low_flag_reg  <= 1'b0;
            ack_flag_reg  <= 1'b0;
            ack_time_reg  <= '0;
            interval_reg  <= blm_pkg::MIN_INT_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
                low_flag_reg  <= low_flag_next;
                ack_flag_reg  <= ack_flag_next;
                ack_time_reg  <= ack_time_next;
                interval_reg  <= interval_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg <= s_tuser;
            in_adc_reg  <= s_tdata[11:0];
            in_now_reg  <= s_tdata[43:12];
        end
    end

    // state registers hold still while the result waits, so they serve as the output word
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, avg, ack_flag_reg, low_flag_reg};

    a_low_needs_level: assert property (@(posedge aclk) disable iff (!aresetn)
        low_flag_reg |-> (avg != '0))
        else $error("battery low flagged with a zero average");

    a_ready_when_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled while output register is empty");

    a_ack_set_latches: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_mode_reg == blm_pkg::MODE_ACK_SET) |=> ack_flag_reg)
        else $error("acknowledge set did not latch");

    a_stall_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> ($stable(avg) && $stable(ack_flag_reg)))
        else $error("result state moved during output stall");

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the battery-low monitor: directed and random stream traffic.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned RING_DEPTH   = 8;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam logic [blm_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Same order as m_tdata, lowest bit last.
    typedef struct packed {
        logic [blm_pkg::LEVEL_W-1:0] filtered_level;
        logic                        low_ack;
        logic                        battery_low;
    } status_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;    // adc_sample[11:0], now_ms[43:12], zero pad
    logic [1:0]  s_tuser = '0;    // mode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // battery_low[0], low_ack[1], filtered_level[21:2]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predicted block state and register copy.
    blm_pkg::cfg_t               cfg_p;
    logic [blm_pkg::LEVEL_W-1:0] avg_p;
    logic [blm_pkg::LEVEL_W-1:0] ring_p [RING_DEPTH];
    int unsigned                 slot_p;
    logic                        low_p;
    logic                        ack_p;
    logic [blm_pkg::TIME_W-1:0]  ack_time_p;
    logic [blm_pkg::TIME_W-1:0]  renotify_p;

    status_t     expected_status_q [$];
    logic [31:0] clock_ms = '0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned error_count = 0;
    int unsigned words_sent = 0;
    int unsigned results_checked = 0;
    int unsigned low_seen = 0;
    int unsigned ack_seen = 0;
    int unsigned cycle_count = 0;

    battery_low_monitor_unit #(.WINDOW_DEPTH(RING_DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_status_q.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("mismatch: %s", msg);
    endtask

    function automatic void reset_prediction();
        cfg_p.alpha_q8        = blm_pkg::ALPHA_RESET;
        cfg_p.low_threshold   = blm_pkg::THRESHOLD_RESET;
        cfg_p.min_interval_ms = blm_pkg::MIN_INT_RESET;
        avg_p      = '0;
        for (int i = 0; i < RING_DEPTH; i++)
            ring_p[i] = '0;
        slot_p     = 0;
        low_p      = 1'b0;
        ack_p      = 1'b0;
        ack_time_p = '0;
        renotify_p = blm_pkg::MIN_INT_RESET;
    endfunction

    function automatic status_t predict_status(input logic [blm_pkg::MODE_W-1:0] mode,
                                               input logic [blm_pkg::ADC_W-1:0] adc,
                                               input logic [blm_pkg::TIME_W-1:0] now);
        logic [blm_pkg::ALPHA_W-1:0] weight;
        logic [63:0]                 mix;
        logic [blm_pkg::TIME_W-1:0]  elapsed;
        logic                        all_low;
        status_t                     st;
        case (mode)
            blm_pkg::MODE_SAMPLE: begin
                // Saturate the weight so one sample can at most replace the average.
                weight = (cfg_p.alpha_q8 > blm_pkg::ALPHA_ONE) ? blm_pkg::ALPHA_ONE
                                                               : cfg_p.alpha_q8;
                mix = 64'(weight) * 64'({adc, 8'h00})
                    + 64'(blm_pkg::ALPHA_ONE - weight) * 64'(avg_p) + 64'd128;
                avg_p = mix[blm_pkg::LEVEL_W+7:8];
                ring_p[slot_p] = avg_p;
                slot_p = (slot_p + 1) % RING_DEPTH;
                all_low = 1'b1;
                for (int i = 0; i < RING_DEPTH; i++)
                    if (!(ring_p[i] != '0 && ring_p[i] < cfg_p.low_threshold))
                        all_low = 1'b0;
                low_p = all_low;
                if (!low_p && ack_p) begin
                    ack_p = 1'b0;
                    renotify_p = cfg_p.min_interval_ms;
                end
                elapsed = now - ack_time_p;
                if (ack_p && elapsed >= renotify_p)
                    ack_p = 1'b0;
            end
            blm_pkg::MODE_ACK_SET: begin
                ack_time_p = now;
                renotify_p = (renotify_p > 32'h7FFF_FFFF) ? '1 : renotify_p << 1;
                ack_p = 1'b1;
            end
            blm_pkg::MODE_ACK_CLEAR: ack_p = 1'b0;
            default: ;
        endcase
        st.battery_low    = low_p;
        st.low_ack        = ack_p;
        st.filtered_level = avg_p;
        return st;
    endfunction

    function automatic logic [31:0] reg_value(input logic [1:0] idx);
        case (idx)
            blm_pkg::REG_ALPHA:     return 32'(cfg_p.alpha_q8);
            blm_pkg::REG_THRESHOLD: return 32'(cfg_p.low_threshold);
            blm_pkg::REG_MIN_INT:   return cfg_p.min_interval_ms;
            default:                return '0;
        endcase
    endfunction

    // Compare each result word with the oldest prediction.
    always @(posedge aclk) begin
        status_t got;
        status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[21:0];
            if (expected_status_q.size() == 0) begin
                note_error("result word with nothing expected");
            end else begin
                want = expected_status_q.pop_front();
                results_checked++;
                if (got.battery_low !== want.battery_low)
                    note_error($sformatf("battery_low exp %0b got %0b (result %0d)",
                                         want.battery_low, got.battery_low, results_checked));
                if (got.low_ack !== want.low_ack)
                    note_error($sformatf("low_ack exp %0b got %0b (result %0d)",
                                         want.low_ack, got.low_ack, results_checked));
                if (got.filtered_level !== want.filtered_level)
                    note_error($sformatf("filtered_level exp %0h got %0h (result %0d)",
                                         want.filtered_level, got.filtered_level,
                                         results_checked));
                if (want.battery_low)
                    low_seen++;
                if (want.low_ack)
                    ack_seen++;
            end
        end
    end

    // Call and return on a falling edge.
    task automatic push_word(input logic [blm_pkg::MODE_W-1:0] mode,
                             input logic [blm_pkg::ADC_W-1:0] adc,
                             input logic [blm_pkg::TIME_W-1:0] now);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'h0, now, adc};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        expected_status_q.push_back(predict_status(mode, adc, now));
        words_sent++;
        @(negedge aclk);
    endtask

    // Hold the input until every predicted word has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic check_reg(input logic [1:0] idx);
        logic [31:0] want;
        want = reg_value(idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (prdata !== want)
            note_error($sformatf("register %0d read exp %0h got %0h", idx, want, prdata));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        case (idx)
            blm_pkg::REG_ALPHA:     cfg_p.alpha_q8        = value[blm_pkg::ALPHA_W-1:0];
            blm_pkg::REG_THRESHOLD: cfg_p.low_threshold   = value[blm_pkg::LEVEL_W-1:0];
            blm_pkg::REG_MIN_INT:   cfg_p.min_interval_ms = value;
            default: ;
        endcase
        @(negedge aclk);
        check_reg(idx);
    endtask

    task automatic apply_config(input logic [31:0] alpha, input logic [31:0] threshold,
                                input logic [31:0] min_interval);
        settle();
        write_reg(blm_pkg::REG_ALPHA, alpha);
        write_reg(blm_pkg::REG_THRESHOLD, threshold);
        write_reg(blm_pkg::REG_MIN_INT, min_interval);
    endtask

    // Mostly small steps, some aimed at the renotify boundary, some anywhere.
    function automatic logic [blm_pkg::TIME_W-1:0] advance_clock();
        case ($urandom_range(9, 0))
            0, 1, 2, 3, 4, 5: clock_ms = clock_ms + $urandom_range(1500, 0);
            6, 7:             clock_ms = clock_ms + $urandom_range(renotify_p, 0);
            8:                clock_ms = ack_time_p + renotify_p - 1 + $urandom_range(2, 0);
            default:          clock_ms = $urandom;
        endcase
        return clock_ms;
    endfunction

    function automatic logic [blm_pkg::ADC_W-1:0] low_adc();
        int unsigned bound;
        bound = cfg_p.low_threshold >> 8;
        if (bound >= 2)
            return 12'($urandom_range(bound - 1, 1));
        return 12'($urandom_range(4095, 0));
    endfunction

    function automatic logic [blm_pkg::ADC_W-1:0] high_adc();
        int unsigned bound;
        bound = cfg_p.low_threshold >> 8;
        if (bound >= 4095)
            return 12'hFFF;
        return 12'($urandom_range(4095, bound + 1));
    endfunction

    task automatic test_after_reset();
        check_reg(blm_pkg::REG_ALPHA);
        check_reg(blm_pkg::REG_THRESHOLD);
        check_reg(blm_pkg::REG_MIN_INT);
        push_word(MODE_UNUSED, 12'hFFF, 32'h0);
        push_word(blm_pkg::MODE_ACK_CLEAR, 12'h000, 32'hFFFF_FFFF);
    endtask

    task automatic test_window_fill();
        settle();
        write_reg(blm_pkg::REG_ALPHA, 32'(blm_pkg::ALPHA_ONE));
        for (int i = 0; i < RING_DEPTH - 1; i++)
            push_word(blm_pkg::MODE_SAMPLE, 12'd1000, 32'(10 + i));
        // Smallest nonzero level completes a fully low window.
        push_word(blm_pkg::MODE_SAMPLE, 12'd1, 32'd20);
    endtask

    task automatic test_ack_latch();
        push_word(blm_pkg::MODE_ACK_SET, 12'h000, 32'hFFFF_FF00);
        push_word(blm_pkg::MODE_SAMPLE, 12'd500, 32'h0000_0010);
        push_word(blm_pkg::MODE_SAMPLE, 12'd500, 32'hFFFF_FF00 + 32'd120000);
        push_word(blm_pkg::MODE_ACK_SET, 12'h000, 32'd5);
        push_word(blm_pkg::MODE_SAMPLE, 12'hFFF, 32'd6);
        push_word(blm_pkg::MODE_ACK_CLEAR, 12'hFFF, 32'd7);
    endtask

    task automatic test_alpha_limits();
        settle();
        write_reg(blm_pkg::REG_ALPHA, 32'h1FF);
        push_word(blm_pkg::MODE_SAMPLE, 12'h000, 32'd8);
        settle();
        write_reg(blm_pkg::REG_ALPHA, 32'h0);
        push_word(blm_pkg::MODE_SAMPLE, 12'hFFF, 32'd9);
    endtask

    task automatic test_interval_saturation();
        settle();
        write_reg(blm_pkg::REG_MIN_INT, 32'h8000_0001);
        push_word(blm_pkg::MODE_ACK_SET, 12'h000, 32'd0);
        // Release reloads the new minimum, the next set must saturate.
        push_word(blm_pkg::MODE_SAMPLE, 12'hFFF, 32'd1);
        push_word(blm_pkg::MODE_ACK_SET, 12'h000, 32'hFFFF_FFFF);
        push_word(blm_pkg::MODE_ACK_CLEAR, 12'h000, 32'd0);
    endtask

    task automatic run_traffic(input int unsigned count);
        int unsigned target;
        int unsigned pause_at;
        target   = words_sent + count;
        pause_at = words_sent + $urandom_range(count - 1, count / 4);
        while (words_sent < target) begin
            if (words_sent >= pause_at) begin
                settle();
                pause_at = target + 1;
            end
            if ($urandom_range(99, 0) < 75) begin
                // Feed low readings, acknowledge, keep sampling, then maybe recover, clear or re-acknowledge.
                repeat ($urandom_range(14, 6))
                    push_word(blm_pkg::MODE_SAMPLE, low_adc(), advance_clock());
                push_word(blm_pkg::MODE_ACK_SET, 12'($urandom_range(4095, 0)),
                          advance_clock());
                repeat ($urandom_range(10, 2))
                    push_word(blm_pkg::MODE_SAMPLE, low_adc(), advance_clock());
                case ($urandom_range(3, 0))
                    0: push_word(blm_pkg::MODE_SAMPLE, high_adc(), advance_clock());
                    1: push_word(blm_pkg::MODE_ACK_CLEAR, 12'($urandom_range(4095, 0)),
                                 advance_clock());
                    2: push_word(blm_pkg::MODE_ACK_SET, 12'($urandom_range(4095, 0)),
                                 advance_clock());
                    default: ;
                endcase
            end else begin
                repeat ($urandom_range(6, 1))
                    push_word(2'($urandom_range(3, 0)), 12'($urandom_range(4095, 0)),
                              advance_clock());
            end
        end
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 3; p++) begin
            case (p)
                0:       begin send_idle_pct = 17; recv_idle_pct = 74; end
                1:       begin send_idle_pct = 74; recv_idle_pct = 17; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            for (int k = 0; k < 3; k++) begin
                case (p * 3 + k)
                    0: apply_config(32'd26, 32'd524288, 32'd60000);
                    1: apply_config(32'd0, 32'hFFFFF, 32'd0);
                    2: apply_config(32'd256, 32'd0, 32'hFFFF_FFFF);
                    3: apply_config(32'h1FF, 32'd600000, 32'd1000);
                    4: apply_config($urandom_range(511, 0), $urandom_range(32'hFFFFF, 0),
                                    $urandom_range(5000, 0));
                    5: apply_config(32'd128, 32'h80000, 32'h8000_0000);
                    6: apply_config($urandom_range(511, 1), $urandom_range(32'hFFFFF, 0),
                                    $urandom);
                    7: apply_config(32'd1, 32'hFFFFF, 32'd1);
                    default: apply_config(32'd300, 32'd400000, 32'd20000);
                endcase
                run_traffic(95);
            end
        end
    endtask

    initial begin
        reset_prediction();
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_after_reset();
        test_window_fill();
        test_ack_latch();
        test_alpha_limits();
        test_interval_saturation();
        test_random_traffic();
        settle();
        $display("covered %0d words, %0d results checked: %0d battery-low, %0d acknowledged",
                 words_sent, results_checked, low_seen, ack_seen);
        $display("directed extremes plus nine register sets under three pacing profiles");
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("%0d mismatches", error_count);
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
